>>> hw/rtl/sice_pkg.sv
package sice_pkg;

	// Default sizing handed to the top level.
	localparam int VALUE_BITS_DEF = 16;
	localparam int MAX_REPEAT_DEF = 16;

	// Output symbol codes.
	localparam logic [1:0] SYM_SPACE = 2'd0;
	localparam logic [1:0] SYM_TAB   = 2'd1;
	localparam logic [1:0] SYM_LF    = 2'd2;

	// Instruction opcodes.
	localparam logic [4:0] KIND_GETC   = 5'd0;
	localparam logic [4:0] KIND_PUTC   = 5'd1;
	localparam logic [4:0] KIND_GETN   = 5'd2;
	localparam logic [4:0] KIND_PUTN   = 5'd3;
	localparam logic [4:0] KIND_PUSH   = 5'd4;
	localparam logic [4:0] KIND_DUP    = 5'd5;
	localparam logic [4:0] KIND_DROP   = 5'd6;
	localparam logic [4:0] KIND_ADD    = 5'd7;
	localparam logic [4:0] KIND_SUB    = 5'd8;
	localparam logic [4:0] KIND_MUL    = 5'd9;
	localparam logic [4:0] KIND_DIV    = 5'd10;
	localparam logic [4:0] KIND_MOD    = 5'd11;
	localparam logic [4:0] KIND_STORE  = 5'd12;
	localparam logic [4:0] KIND_RECALL = 5'd13;
	localparam logic [4:0] KIND_CALL   = 5'd14;
	localparam logic [4:0] KIND_JUMP   = 5'd15;
	localparam logic [4:0] KIND_BZ     = 5'd16;
	localparam logic [4:0] KIND_BLTZ   = 5'd17;
	localparam logic [4:0] KIND_RET    = 5'd18;
	localparam logic [4:0] KIND_SWAP   = 5'd19;
	localparam logic [4:0] KIND_STOP   = 5'd20;
	localparam logic [4:0] KIND_LABEL  = 5'd21;
	localparam logic [4:0] KIND_COPY   = 5'd22;
	localparam logic [4:0] KIND_SLIDE  = 5'd23;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ERR,
		ST_PFX1,
		ST_PFX2,
		ST_SIGN,
		ST_BITS,
		ST_LF,
		ST_OP
	} state_t;

	// Source of the symbol written into the output register.
	typedef enum logic [2:0] {
		SEL_SPACE,
		SEL_LF,
		SEL_SIGN,
		SEL_BIT,
		SEL_OP
	} sel_t;

	// Decoded instruction.
	typedef struct packed {
		logic            err;
		logic            warn;
		logic            push1;
		logic            push2;
		logic            num_after;
		logic            num_signed;
		logic            op_len4;
		logic [3:0][1:0] op_sym;
	} dec_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_dec;
		logic num_load;
		logic num_sel;
		logic op_step;
		logic bit_step;
		logic emit;
		sel_t sel;
		logic last;
		logic err;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic mag_zero;
		logic idx_zero;
		logic v1_zero;
		logic op_end;
		logic rep_zero;
		logic push1;
		logic push2;
		logic num_after;
		logic num_signed;
		logic err;
	} stat_t;

	// Operation symbol strings, first symbol in element zero.
	function automatic logic [3:0][1:0] ops4(input logic [1:0] a, input logic [1:0] b,
			input logic [1:0] c, input logic [1:0] d);
		logic [3:0][1:0] r;
		r[0] = a;
		r[1] = b;
		r[2] = c;
		r[3] = d;
		return r;
	endfunction

	function automatic logic [3:0][1:0] ops3(input logic [1:0] a, input logic [1:0] b,
			input logic [1:0] c);
		return ops4(a, b, c, SYM_SPACE);
	endfunction

endpackage

>>> hw/rtl/sice_decode.sv
module sice_decode #(
	parameter int VALUE_BITS = sice_pkg::VALUE_BITS_DEF,
	parameter int MAX_REPEAT = sice_pkg::MAX_REPEAT_DEF
) (
	input  logic [4:0]                        kind,
	input  logic                              first_present,
	input  logic                              second_present,
	input  logic signed [15:0]                first_value,
	input  logic signed [15:0]                second_value,
	output sice_pkg::dec_t                    dec,
	output logic [$clog2(MAX_REPEAT+1)-1:0]   rep,
	output logic signed [15:0]                v1,
	output logic signed [15:0]                v2
);
	import sice_pkg::*;

	localparam int REP_W = $clog2(MAX_REPEAT + 1);
	localparam int VMAX  = (2 ** (VALUE_BITS - 1)) - 1;
	localparam int VMIN  = -(2 ** (VALUE_BITS - 1));

	logic             s1_ok;
	logic             s2_ok;
	logic             l1_ok;
	logic             rep_ok;
	logic             rep_form;
	logic             bad_kind;
	logic [1:0]       tail_c;
	logic [1:0]       tail_d;

	// Operand selection and range checks.
	always_comb begin
		v1     = first_present ? first_value : 16'sd0;
		v2     = second_present ? second_value : 16'sd0;
		s1_ok  = (int'(v1) >= VMIN) && (int'(v1) <= VMAX);
		s2_ok  = (int'(v2) >= VMIN) && (int'(v2) <= VMAX);
		l1_ok  = !v1[15] && s1_ok;
		rep_ok = !v1[15] && (int'(v1) <= MAX_REPEAT);
	end

	// Opcode decode into segments: pushes, repeated operation, trailing number.
	always_comb begin
		dec      = '0;
		rep      = REP_W'(1);
		rep_form = 1'b0;
		bad_kind = 1'b0;
		tail_c   = SYM_SPACE;
		tail_d   = SYM_SPACE;
		case (kind)
			KIND_GETC: begin
				dec.push1   = first_present;
				dec.op_sym  = ops4(SYM_TAB, SYM_LF, SYM_TAB, SYM_SPACE);
				dec.op_len4 = 1'b1;
			end
			KIND_PUTC: begin
				if (second_present) begin
					rep_form = 1'b1;
					rep      = v1[REP_W-1:0];
				end else begin
					dec.push1 = first_present;
				end
				dec.op_sym  = ops4(SYM_TAB, SYM_LF, SYM_SPACE, SYM_SPACE);
				dec.op_len4 = 1'b1;
			end
			KIND_GETN: begin
				dec.push1   = first_present;
				dec.op_sym  = ops4(SYM_TAB, SYM_LF, SYM_TAB, SYM_TAB);
				dec.op_len4 = 1'b1;
			end
			KIND_PUTN: begin
				if (second_present) begin
					rep_form = 1'b1;
					rep      = v1[REP_W-1:0];
				end else begin
					dec.push1 = first_present;
				end
				dec.op_sym  = ops4(SYM_TAB, SYM_LF, SYM_SPACE, SYM_TAB);
				dec.op_len4 = 1'b1;
			end
			KIND_PUSH: begin
				dec.push1 = 1'b1;
				rep       = '0;
			end
			KIND_DUP: begin
				if (first_present) begin
					rep_form = 1'b1;
					rep      = v1[REP_W-1:0];
				end
				dec.op_sym = ops3(SYM_SPACE, SYM_LF, SYM_SPACE);
			end
			KIND_DROP: begin
				if (first_present) begin
					rep_form = 1'b1;
					rep      = v1[REP_W-1:0];
				end
				dec.op_sym = ops3(SYM_SPACE, SYM_LF, SYM_LF);
			end
			KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV, KIND_MOD: begin
				case (kind)
					KIND_ADD: begin
						tail_c = SYM_SPACE;
						tail_d = SYM_SPACE;
					end
					KIND_SUB: begin
						tail_c = SYM_SPACE;
						tail_d = SYM_TAB;
					end
					KIND_MUL: begin
						tail_c = SYM_SPACE;
						tail_d = SYM_LF;
					end
					KIND_DIV: begin
						tail_c = SYM_TAB;
						tail_d = SYM_SPACE;
					end
					default: begin
						tail_c = SYM_TAB;
						tail_d = SYM_TAB;
					end
				endcase
				if (second_present) begin
					rep_form = 1'b1;
					rep      = v1[REP_W-1:0];
				end else begin
					dec.push1 = first_present;
					dec.warn  = first_present && (v1 == 16'sd0) &&
						((kind == KIND_DIV) || (kind == KIND_MOD));
				end
				dec.op_sym  = ops4(SYM_TAB, SYM_SPACE, tail_c, tail_d);
				dec.op_len4 = 1'b1;
			end
			KIND_STORE: begin
				dec.push1  = first_present | second_present;
				dec.push2  = second_present;
				dec.op_sym = ops3(SYM_TAB, SYM_TAB, SYM_SPACE);
			end
			KIND_RECALL: begin
				dec.push1  = first_present;
				dec.op_sym = ops3(SYM_TAB, SYM_TAB, SYM_TAB);
			end
			KIND_CALL: begin
				dec.num_after = 1'b1;
				dec.op_sym    = ops3(SYM_LF, SYM_SPACE, SYM_TAB);
			end
			KIND_JUMP: begin
				dec.num_after = 1'b1;
				dec.op_sym    = ops3(SYM_LF, SYM_SPACE, SYM_LF);
			end
			KIND_BZ: begin
				dec.num_after = 1'b1;
				dec.op_sym    = ops3(SYM_LF, SYM_TAB, SYM_SPACE);
			end
			KIND_BLTZ: begin
				dec.num_after = 1'b1;
				dec.op_sym    = ops3(SYM_LF, SYM_TAB, SYM_TAB);
			end
			KIND_RET: begin
				dec.op_sym = ops3(SYM_LF, SYM_TAB, SYM_LF);
			end
			KIND_SWAP: begin
				dec.op_sym = ops3(SYM_SPACE, SYM_LF, SYM_TAB);
			end
			KIND_STOP: begin
				dec.op_sym = ops3(SYM_LF, SYM_LF, SYM_LF);
			end
			KIND_LABEL: begin
				dec.num_after = 1'b1;
				dec.op_sym    = ops3(SYM_LF, SYM_SPACE, SYM_SPACE);
			end
			KIND_COPY: begin
				dec.num_after  = 1'b1;
				dec.num_signed = 1'b1;
				dec.op_sym     = ops3(SYM_SPACE, SYM_TAB, SYM_SPACE);
			end
			KIND_SLIDE: begin
				dec.num_after  = 1'b1;
				dec.num_signed = 1'b1;
				dec.op_sym     = ops3(SYM_SPACE, SYM_TAB, SYM_LF);
			end
			default: begin
				bad_kind = 1'b1;
			end
		endcase
		dec.err = bad_kind
			| (dec.push1 & !s1_ok)
			| (dec.push2 & !s2_ok)
			| (dec.num_after & dec.num_signed & !s1_ok)
			| (dec.num_after & !dec.num_signed & !l1_ok)
			| (rep_form & !rep_ok);
	end

endmodule

>>> hw/rtl/sice_ctrl.sv
module sice_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  sice_pkg::stat_t stat,
	output sice_pkg::cmd_t  cmd
);
	import sice_pkg::*;

	state_t state_q;
	state_t state_n;
	logic   num2_q;
	logic   num2_n;
	logic   post_q;
	logic   post_n;
	logic   pend2;

	// State register and segment flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			num2_q  <= 1'b0;
			post_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			num2_q  <= num2_n;
			post_q  <= post_n;
		end
	end

	// Next state and commands; every symbol step waits for a free output register.
	always_comb begin
		state_n  = state_q;
		num2_n   = num2_q;
		post_n   = post_q;
		cmd      = '0;
		cmd.sel  = SEL_SPACE;
		in_ready = 1'b0;
		pend2    = !num2_q && stat.push2;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_dec = 1'b1;
					state_n      = ST_LOAD;
				end
			end
			ST_LOAD: begin
				num2_n = 1'b0;
				post_n = 1'b0;
				if (stat.err) begin
					state_n = ST_ERR;
				end else if (stat.push1) begin
					state_n = ST_PFX1;
				end else if (!stat.rep_zero) begin
					state_n = ST_OP;
				end else begin
					state_n = ST_IDLE;
				end
			end
			ST_ERR: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = SEL_SPACE;
					cmd.last = 1'b1;
					cmd.err  = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			ST_PFX1: begin
				if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.sel      = SEL_SPACE;
					cmd.num_load = 1'b1;
					cmd.num_sel  = num2_q;
					state_n      = ST_PFX2;
				end
			end
			ST_PFX2: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = SEL_SPACE;
					state_n  = ST_SIGN;
				end
			end
			ST_SIGN: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = SEL_SIGN;
					state_n  = stat.mag_zero ? ST_LF : ST_BITS;
				end
			end
			ST_BITS: begin
				if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.sel      = SEL_BIT;
					cmd.bit_step = 1'b1;
					if (stat.idx_zero) begin
						state_n = ST_LF;
					end
				end
			end
			ST_LF: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = SEL_LF;
					cmd.last = post_q || (!pend2 && stat.rep_zero);
					if (post_q) begin
						state_n = ST_IDLE;
					end else if (pend2) begin
						num2_n  = 1'b1;
						state_n = ST_PFX1;
					end else if (!stat.rep_zero) begin
						state_n = ST_OP;
					end else begin
						state_n = ST_IDLE;
					end
				end
			end
			ST_OP: begin
				if (stat.out_free) begin
					cmd.emit    = 1'b1;
					cmd.sel     = SEL_OP;
					cmd.op_step = 1'b1;
					cmd.last    = stat.op_end && !stat.num_after;
					if (stat.op_end) begin
						if (stat.num_after) begin
							cmd.num_load = 1'b1;
							cmd.num_sel  = 1'b0;
							post_n       = 1'b1;
							if (stat.num_signed) begin
								state_n = ST_SIGN;
							end else begin
								state_n = stat.v1_zero ? ST_LF : ST_BITS;
							end
						end else begin
							state_n = ST_IDLE;
						end
					end
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/sice_dp.sv
module sice_dp #(
	parameter int VALUE_BITS = sice_pkg::VALUE_BITS_DEF,
	parameter int MAX_REPEAT = sice_pkg::MAX_REPEAT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sice_pkg::cmd_t                  cmd,
	input  sice_pkg::dec_t                  dec_n,
	input  logic [$clog2(MAX_REPEAT+1)-1:0] rep_n,
	input  logic signed [15:0]              v1_n,
	input  logic signed [15:0]              v2_n,
	output sice_pkg::stat_t                 stat,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      symbol,
	output logic                            last,
	output logic                            div_zero_warning,
	output logic                            range_error
);
	import sice_pkg::*;

	localparam int REP_W = $clog2(MAX_REPEAT + 1);
	localparam int MAG_W = (VALUE_BITS < 16) ? VALUE_BITS : 16;
	localparam int IDX_W = $clog2(MAG_W);

	dec_t             dec_q;
	logic [REP_W-1:0] rep_q;
	logic [1:0]       opi_q;
	logic             v1_neg_q;
	logic [MAG_W-1:0] v1_mag_q;
	logic             v2_neg_q;
	logic [MAG_W-1:0] v2_mag_q;
	logic             neg_q;
	logic [MAG_W-1:0] mag_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic [1:0]       symbol_q;
	logic             last_q;
	logic             warn_q;
	logic             err_q;

	logic [16:0]      v1_abs;
	logic [16:0]      v2_abs;
	logic [MAG_W-1:0] ld_mag;
	logic             ld_neg;
	logic [IDX_W-1:0] ld_top;
	logic [1:0]       op_last;
	logic [1:0]       sym_n;

	// Magnitudes of the two operands.
	always_comb begin
		v1_abs = v1_n[15] ? (17'd0 - {v1_n[15], v1_n}) : {1'b0, v1_n};
		v2_abs = v2_n[15] ? (17'd0 - {v2_n[15], v2_n}) : {1'b0, v2_n};
	end

	// Number source for the bit shifter and its most significant set bit.
	always_comb begin
		ld_mag = cmd.num_sel ? v2_mag_q : v1_mag_q;
		ld_neg = cmd.num_sel ? v2_neg_q : v1_neg_q;
		ld_top = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (ld_mag[i]) begin
				ld_top = IDX_W'(i);
			end
		end
	end

	// Decoded instruction and operands, held for the whole instruction.
	always_ff @(posedge clk) begin
		if (cmd.load_dec) begin
			dec_q    <= dec_n;
			v1_neg_q <= v1_n[15];
			v1_mag_q <= v1_abs[MAG_W-1:0];
			v2_neg_q <= v2_n[15];
			v2_mag_q <= v2_abs[MAG_W-1:0];
		end
		if (cmd.num_load) begin
			neg_q <= ld_neg;
			mag_q <= ld_mag;
		end
	end

	// Operation symbol index and repeat counter; bit index of the number.
	always_comb begin
		op_last = dec_q.op_len4 ? 2'd3 : 2'd2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_q <= '0;
			opi_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.load_dec) begin
				rep_q <= rep_n;
				opi_q <= '0;
			end else if (cmd.op_step) begin
				if (opi_q == op_last) begin
					opi_q <= '0;
					rep_q <= rep_q - REP_W'(1);
				end else begin
					opi_q <= opi_q + 2'd1;
				end
			end
			if (cmd.num_load) begin
				idx_q <= ld_top;
			end else if (cmd.bit_step) begin
				idx_q <= idx_q - IDX_W'(1);
			end
		end
	end

	// Symbol selection for the beat being written.
	always_comb begin
		case (cmd.sel)
			SEL_SPACE: sym_n = SYM_SPACE;
			SEL_LF:    sym_n = SYM_LF;
			SEL_SIGN:  sym_n = neg_q ? SYM_TAB : SYM_SPACE;
			SEL_BIT:   sym_n = mag_q[idx_q] ? SYM_TAB : SYM_SPACE;
			SEL_OP:    sym_n = dec_q.op_sym[opi_q];
			default:   sym_n = SYM_SPACE;
		endcase
	end

	// Output register: a new beat is written when the slot is empty or being taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			symbol_q <= sym_n;
			last_q   <= cmd.last;
			warn_q   <= dec_q.warn && !cmd.err;
			err_q    <= cmd.err;
		end
	end

	assign out_valid        = out_valid_q;
	assign symbol           = symbol_q;
	assign last             = last_q;
	assign div_zero_warning = warn_q;
	assign range_error      = err_q;

	// Status towards the controller.
	always_comb begin
		stat            = '0;
		stat.out_free   = !out_valid_q || out_ready;
		stat.mag_zero   = (mag_q == '0);
		stat.idx_zero   = (idx_q == '0);
		stat.v1_zero    = (v1_mag_q == '0);
		stat.op_end     = (opi_q == op_last) && (rep_q == REP_W'(1));
		stat.rep_zero   = (rep_q == '0);
		stat.push1      = dec_q.push1;
		stat.push2      = dec_q.push2;
		stat.num_after  = dec_q.num_after;
		stat.num_signed = dec_q.num_signed;
		stat.err        = dec_q.err;
	end

endmodule

>>> hw/rtl/stack_instruction_char_encoder.sv
// An accepted beat is registered and checked in the controller's load state, then its first
// symbol is written into the output register once that is free. Throughput: one symbol per
// cycle while the consumer is ready; an instruction of N symbols (N from 0 to 64) is stepped
// by the controller into the output register. The next instruction is accepted once the last
// symbol of the current one has been written, even while that symbol still waits.
// Reset: arst_n low clears the controller, the counters and the output valid at once.
module stack_instruction_char_encoder #(
	parameter int VALUE_BITS = sice_pkg::VALUE_BITS_DEF,
	parameter int MAX_REPEAT = sice_pkg::MAX_REPEAT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [4:0]         kind,
	input  logic               first_present,
	input  logic               second_present,
	input  logic signed [15:0] first_value,
	input  logic signed [15:0] second_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         symbol,
	output logic               last,
	output logic               div_zero_warning,
	output logic               range_error
);
	import sice_pkg::*;

	localparam int REP_W = $clog2(MAX_REPEAT + 1);

	dec_t               dec;
	logic [REP_W-1:0]   rep;
	logic signed [15:0] v1;
	logic signed [15:0] v2;
	cmd_t               cmd;
	stat_t              stat;

	// Instruction decode and range checks.
	sice_decode #(
		.VALUE_BITS(VALUE_BITS),
		.MAX_REPEAT(MAX_REPEAT)
	) u_decode (
		.kind          (kind),
		.first_present (first_present),
		.second_present(second_present),
		.first_value   (first_value),
		.second_value  (second_value),
		.dec           (dec),
		.rep           (rep),
		.v1            (v1),
		.v2            (v2)
	);

	// Segment sequencer.
	sice_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// Operand registers, counters, bit shifter and output register.
	sice_dp #(
		.VALUE_BITS(VALUE_BITS),
		.MAX_REPEAT(MAX_REPEAT)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.dec_n           (dec),
		.rep_n           (rep),
		.v1_n            (v1),
		.v2_n            (v2),
		.stat            (stat),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.symbol          (symbol),
		.last            (last),
		.div_zero_warning(div_zero_warning),
		.range_error     (range_error)
	);

endmodule

>>> hw/rtl/sice_checker.sv
module sice_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  symbol,
	input logic        last,
	input logic        div_zero_warning,
	input logic        range_error
);
	import sice_pkg::*;

	// An error beat is a lone space that ends the instruction and carries no warning.
	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> last && (symbol == SYM_SPACE) && !div_zero_warning)
		else $error("error beat malformed");

	// Only the three symbol codes ever appear.
	a_sym_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (symbol == SYM_SPACE) || (symbol == SYM_TAB) || (symbol == SYM_LF))
		else $error("illegal symbol code");

	// A new instruction is never taken in the cycle after one was accepted.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken during decode");

	// While a beat that is not the last one is shown, the instruction is still in flight.
	a_busy_mid_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("input ready mid instruction");

	// A stalled beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(symbol) && $stable(last))
		else $error("stalled beat changed");

endmodule

bind stack_instruction_char_encoder sice_checker u_sice_checker (.*);

>>> sim/symbol_stream_checker.sv
// Watches both channels of the encoder, works out the symbol run that each accepted
// instruction should produce and compares every output beat with the oldest one waiting.
module symbol_stream_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [4:0]         kind,
	input  logic               first_present,
	input  logic               second_present,
	input  logic signed [15:0] first_value,
	input  logic signed [15:0] second_value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [1:0]         symbol,
	input  logic               last,
	input  logic               div_zero_warning,
	input  logic               range_error,
	output int                 fail_count,
	output int                 pending,
	output int                 item_count,
	output int                 symbol_count,
	output int                 error_count,
	output int                 warning_count
);
	import sice_pkg::*;

	localparam int VALUE_BITS  = VALUE_BITS_DEF;
	localparam int MAX_REPEAT  = MAX_REPEAT_DEF;
	localparam int MAX_SYMBOLS = 64;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [1:0] symbol;
		logic       last;
		logic       warn;
		logic       err;
	} symbol_beat_t;

	symbol_beat_t expected_symbols[$];

	// Scratch run built up for one instruction.
	logic [1:0] run_buf[MAX_SYMBOLS];
	int         run_len;
	bit         run_bad;

	int fails;
	int reports;
	int items;
	int symbols;
	int errors;
	int warnings;

	// Appends one symbol, dropping anything beyond the longest run.
	task automatic emit(input logic [1:0] s);
		if (run_len < MAX_SYMBOLS) begin
			run_buf[run_len] = s;
			run_len = run_len + 1;
		end
	endtask

	task automatic emit_op3(input logic [1:0] a, input logic [1:0] b, input logic [1:0] c);
		emit(a);
		emit(b);
		emit(c);
	endtask

	// Magnitude bits from the most significant set bit down, closed by a linefeed.
	task automatic emit_magnitude(input logic [31:0] mag);
		int top;
		int i;
		top = -1;
		for (i = 31; i >= 0; i--) begin
			if (mag[i] && top < 0)
				top = i;
		end
		for (i = top; i >= 0; i--)
			emit(mag[i] ? SYM_TAB : SYM_SPACE);
		emit(SYM_LF);
	endtask

	function automatic bit fits_signed(input longint v);
		longint lo;
		longint hi;
		lo = -(longint'(1) << (VALUE_BITS - 1));
		hi = (longint'(1) << (VALUE_BITS - 1)) - 1;
		return v >= lo && v <= hi;
	endfunction

	// Signed number: sign symbol, then the magnitude.
	task automatic emit_number(input int v);
		logic [31:0] mag;
		if (!fits_signed(v)) begin
			run_bad = 1'b1;
		end else if (v < 0) begin
			emit(SYM_TAB);
			mag = 32'(-longint'(v));
			emit_magnitude(mag);
		end else begin
			emit(SYM_SPACE);
			emit_magnitude(32'(v));
		end
	endtask

	// Label number: unsigned, no sign symbol.
	task automatic emit_label(input int v);
		if (v < 0 || !fits_signed(v))
			run_bad = 1'b1;
		else
			emit_magnitude(32'(v));
	endtask

	task automatic emit_push(input int v);
		emit(SYM_SPACE);
		emit(SYM_SPACE);
		emit_number(v);
	endtask

	// Repeat form: the operation string a given number of times.
	task automatic emit_repeat(input int n, input logic [1:0] a, input logic [1:0] b,
			input logic [1:0] c, input logic [1:0] d, input bit four);
		int i;
		if (n < 0 || n > MAX_REPEAT) begin
			run_bad = 1'b1;
		end else begin
			for (i = 0; i < n; i++) begin
				emit_op3(a, b, c);
				if (four)
					emit(d);
			end
		end
	endtask

	// Builds the run for one instruction and queues one expected beat per symbol.
	task automatic encode_instruction(input logic [4:0] k, input logic p1, input logic p2,
			input logic signed [15:0] f, input logic signed [15:0] s);
		int           v1;
		int           v2;
		bit           warn;
		logic [1:0]   c;
		logic [1:0]   d;
		int           i;
		symbol_beat_t b;
		v1 = p1 ? int'(f) : 0;
		v2 = p2 ? int'(s) : 0;
		warn = 1'b0;
		c = SYM_SPACE;
		d = SYM_SPACE;
		run_len = 0;
		run_bad = 1'b0;
		case (k)
		KIND_GETC: begin
			if (p1)
				emit_push(v1);
			emit_op3(SYM_TAB, SYM_LF, SYM_TAB);
			emit(SYM_SPACE);
		end
		KIND_PUTC: begin
			if (p2) begin
				emit_repeat(v1, SYM_TAB, SYM_LF, SYM_SPACE, SYM_SPACE, 1'b1);
			end else begin
				if (p1)
					emit_push(v1);
				emit_op3(SYM_TAB, SYM_LF, SYM_SPACE);
				emit(SYM_SPACE);
			end
		end
		KIND_GETN: begin
			if (p1)
				emit_push(v1);
			emit_op3(SYM_TAB, SYM_LF, SYM_TAB);
			emit(SYM_TAB);
		end
		KIND_PUTN: begin
			if (p2) begin
				emit_repeat(v1, SYM_TAB, SYM_LF, SYM_SPACE, SYM_TAB, 1'b1);
			end else begin
				if (p1)
					emit_push(v1);
				emit_op3(SYM_TAB, SYM_LF, SYM_SPACE);
				emit(SYM_TAB);
			end
		end
		KIND_PUSH: emit_push(v1);
		KIND_DUP: begin
			if (p1)
				emit_repeat(v1, SYM_SPACE, SYM_LF, SYM_SPACE, SYM_SPACE, 1'b0);
			else
				emit_op3(SYM_SPACE, SYM_LF, SYM_SPACE);
		end
		KIND_DROP: begin
			if (p1)
				emit_repeat(v1, SYM_SPACE, SYM_LF, SYM_LF, SYM_SPACE, 1'b0);
			else
				emit_op3(SYM_SPACE, SYM_LF, SYM_LF);
		end
		KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV, KIND_MOD: begin
			// The last two symbols pick the arithmetic operation.
			case (k)
			KIND_ADD: begin
				c = SYM_SPACE;
				d = SYM_SPACE;
			end
			KIND_SUB: begin
				c = SYM_SPACE;
				d = SYM_TAB;
			end
			KIND_MUL: begin
				c = SYM_SPACE;
				d = SYM_LF;
			end
			KIND_DIV: begin
				c = SYM_TAB;
				d = SYM_SPACE;
			end
			default: begin
				c = SYM_TAB;
				d = SYM_TAB;
			end
			endcase
			if (p2) begin
				emit_repeat(v1, SYM_TAB, SYM_SPACE, c, d, 1'b1);
			end else begin
				if (p1) begin
					if ((k == KIND_DIV || k == KIND_MOD) && v1 == 0)
						warn = 1'b1;
					emit_push(v1);
				end
				emit_op3(SYM_TAB, SYM_SPACE, c);
				emit(d);
			end
		end
		KIND_STORE: begin
			if (p2) begin
				emit_push(v1);
				emit_push(v2);
			end else if (p1) begin
				emit_push(v1);
			end
			emit_op3(SYM_TAB, SYM_TAB, SYM_SPACE);
		end
		KIND_RECALL: begin
			if (p1)
				emit_push(v1);
			emit_op3(SYM_TAB, SYM_TAB, SYM_TAB);
		end
		KIND_CALL: begin
			emit_op3(SYM_LF, SYM_SPACE, SYM_TAB);
			emit_label(v1);
		end
		KIND_JUMP: begin
			emit_op3(SYM_LF, SYM_SPACE, SYM_LF);
			emit_label(v1);
		end
		KIND_BZ: begin
			emit_op3(SYM_LF, SYM_TAB, SYM_SPACE);
			emit_label(v1);
		end
		KIND_BLTZ: begin
			emit_op3(SYM_LF, SYM_TAB, SYM_TAB);
			emit_label(v1);
		end
		KIND_RET: emit_op3(SYM_LF, SYM_TAB, SYM_LF);
		KIND_SWAP: emit_op3(SYM_SPACE, SYM_LF, SYM_TAB);
		KIND_STOP: emit_op3(SYM_LF, SYM_LF, SYM_LF);
		KIND_LABEL: begin
			emit_op3(SYM_LF, SYM_SPACE, SYM_SPACE);
			emit_label(v1);
		end
		KIND_COPY: begin
			emit_op3(SYM_SPACE, SYM_TAB, SYM_SPACE);
			emit_number(v1);
		end
		KIND_SLIDE: begin
			emit_op3(SYM_SPACE, SYM_TAB, SYM_LF);
			emit_number(v1);
		end
		default: run_bad = 1'b1;
		endcase

		// An error replaces the whole run with a single flagged beat.
		if (run_bad) begin
			b.symbol = SYM_SPACE;
			b.last = 1'b1;
			b.warn = 1'b0;
			b.err = 1'b1;
			expected_symbols.push_back(b);
			symbols++;
			errors++;
		end else begin
			for (i = 0; i < run_len; i++) begin
				b.symbol = run_buf[i];
				b.last = (i == run_len - 1);
				b.warn = warn;
				b.err = 1'b0;
				expected_symbols.push_back(b);
				symbols++;
				if (warn)
					warnings++;
			end
		end
	endtask

	// Instruction beats are taken first so that a run is queued before any of it appears.
	always @(posedge clk or negedge arst_n) begin
		symbol_beat_t want;
		if (!arst_n) begin
			expected_symbols.delete();
			fails = 0;
			reports = 0;
			items = 0;
			symbols = 0;
			errors = 0;
			warnings = 0;
			fail_count <= 0;
			pending <= 0;
			item_count <= 0;
			symbol_count <= 0;
			error_count <= 0;
			warning_count <= 0;
		end else begin
			if (in_valid && in_ready) begin
				encode_instruction(kind, first_present, second_present, first_value,
					second_value);
				items++;
			end
			if (out_valid && out_ready) begin
				if (expected_symbols.size() == 0) begin
					fails++;
					if (reports < MAX_REPORTS) begin
						reports++;
						$display("mismatch: unexpected beat symbol=%0d last=%0b warn=%0b err=%0b",
							symbol, last, div_zero_warning, range_error);
					end
				end else begin
					want = expected_symbols.pop_front();
					if (symbol !== want.symbol || last !== want.last ||
							div_zero_warning !== want.warn || range_error !== want.err) begin
						fails++;
						if (reports < MAX_REPORTS) begin
							reports++;
							$display("mismatch: expected symbol=%0d last=%0b warn=%0b err=%0b,",
								want.symbol, want.last, want.warn, want.err,
								" got symbol=%0d last=%0b warn=%0b err=%0b",
								symbol, last, div_zero_warning, range_error);
						end
					end
				end
			end
			fail_count <= fails;
			pending <= expected_symbols.size();
			item_count <= items;
			symbol_count <= symbols;
			error_count <= errors;
			warning_count <= warnings;
		end
	end

endmodule

>>> sim/stack_instruction_char_encoder_tb.sv
// Drives instructions into the encoder, paces the symbol consumer and gives the verdict.
module stack_instruction_char_encoder_tb;
	import sice_pkg::*;

	localparam int RANDOM_ITEMS  = 350;
	localparam int HOLD_AT       = 20;
	localparam int QUIET_FROM    = 290;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 16;
	localparam int CYCLE_LIMIT   = 400000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [4:0]         kind = KIND_GETC;
	logic               first_present = 1'b0;
	logic               second_present = 1'b0;
	logic signed [15:0] first_value = '0;
	logic signed [15:0] second_value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         symbol;
	logic               last;
	logic               div_zero_warning;
	logic               range_error;

	int fail_count;
	int pending;
	int item_count;
	int symbol_count;
	int error_count;
	int warning_count;

	bit          idle_on = 1'b1;
	bit          hold_start = 1'b0;
	bit          hold_done = 1'b0;
	int unsigned cycle_count = 0;

	stack_instruction_char_encoder DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (kind),
		.first_present   (first_present),
		.second_present  (second_present),
		.first_value     (first_value),
		.second_value    (second_value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.symbol          (symbol),
		.last            (last),
		.div_zero_warning(div_zero_warning),
		.range_error     (range_error)
	);

	symbol_stream_checker stream_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (kind),
		.first_present   (first_present),
		.second_present  (second_present),
		.first_value     (first_value),
		.second_value    (second_value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.symbol          (symbol),
		.last            (last),
		.div_zero_warning(div_zero_warning),
		.range_error     (range_error),
		.fail_count      (fail_count),
		.pending         (pending),
		.item_count      (item_count),
		.symbol_count    (symbol_count),
		.error_count     (error_count),
		.warning_count   (warning_count)
	);

	always #1 clk = ~clk;

	// Run time guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Consumer: one long hold-off on request, otherwise short random stalls.
	initial begin : consumer
		@(posedge clk);
		forever begin
			if (hold_start && !hold_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Offers one instruction beat and waits for it to be taken, then perhaps idles.
	task automatic send_instr(input logic [4:0] k, input logic p1, input logic p2,
			input logic signed [15:0] v1, input logic signed [15:0] v2);
		in_valid <= 1'b1;
		kind <= k;
		first_present <= p1;
		second_present <= p2;
		first_value <= v1;
		second_value <= v2;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// Operand values weighted towards zero, small numbers and the extremes.
	function automatic logic signed [15:0] rand_operand();
		case ($urandom_range(0, 5))
		0: return 16'sd0;
		1: return 16'($urandom_range(0, 31)) - 16'sd16;
		2: begin
			case ($urandom_range(0, 3))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return -16'sd1;
			default: return 16'sd1;
			endcase
		end
		default: return 16'($urandom);
		endcase
	endfunction

	initial begin : stimulus
		logic [4:0]         k;
		logic               p1;
		logic               p2;
		logic signed [15:0] v1;
		logic signed [15:0] v2;
		bit                 repeat_form;
		bit                 label_form;
		int                 n;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: every opcode, the value extremes and the special cases.
		send_instr(KIND_GETC,   1'b0, 1'b0, 16'sd0,      16'sd0);
		send_instr(KIND_GETC,   1'b1, 1'b0, 16'sh7FFF,   16'sd0);
		send_instr(KIND_PUTC,   1'b1, 1'b0, 16'sh8000,   16'sh7FFF);
		send_instr(KIND_PUTC,   1'b0, 1'b1, 16'sd16,     16'sd0);
		send_instr(KIND_PUTC,   1'b1, 1'b1, 16'sd16,     16'sh8000);
		send_instr(KIND_PUTN,   1'b1, 1'b1, 16'sd0,      16'sd0);
		send_instr(KIND_PUTN,   1'b1, 1'b1, 16'sd17,     16'sd0);
		send_instr(KIND_PUTN,   1'b1, 1'b1, -16'sd1,     16'sd0);
		send_instr(KIND_GETN,   1'b1, 1'b0, 16'sd0,      16'sd0);
		send_instr(KIND_PUSH,   1'b0, 1'b0, 16'sh7FFF,   16'sd0);
		send_instr(KIND_PUSH,   1'b1, 1'b0, -16'sd5,     16'sd0);
		send_instr(KIND_DUP,    1'b0, 1'b0, 16'sd0,      16'sd0);
		send_instr(KIND_DUP,    1'b1, 1'b0, 16'sd3,      16'sd0);
		send_instr(KIND_DROP,   1'b1, 1'b0, 16'sd16,     16'sd0);
		send_instr(KIND_ADD,    1'b1, 1'b1, 16'sd2,      16'sd0);
		send_instr(KIND_SUB,    1'b1, 1'b0, 16'sh8000,   16'sd0);
		send_instr(KIND_MUL,    1'b0, 1'b0, 16'sd0,      16'sd0);
		send_instr(KIND_DIV,    1'b1, 1'b0, 16'sd0,      16'sd0);
		send_instr(KIND_MOD,    1'b1, 1'b0, 16'sd0,      16'sd0);
		send_instr(KIND_DIV,    1'b1, 1'b1, 16'sd0,      16'sd0);
		send_instr(KIND_STORE,  1'b1, 1'b1, 16'sh8000,   16'sh7FFF);
		send_instr(KIND_STORE,  1'b0, 1'b1, 16'sd0,      -16'sd1);
		send_instr(KIND_RECALL, 1'b1, 1'b0, -16'sd1,     16'sd0);
		send_instr(KIND_CALL,   1'b1, 1'b0, 16'sd0,      16'sd0);
		send_instr(KIND_JUMP,   1'b1, 1'b0, 16'sh7FFF,   16'sd0);
		send_instr(KIND_BZ,     1'b1, 1'b0, -16'sd1,     16'sd0);
		send_instr(KIND_BLTZ,   1'b0, 1'b0, 16'sd9,      16'sd0);
		send_instr(KIND_RET,    1'b0, 1'b0, 16'sd0,      16'sd0);
		send_instr(KIND_SWAP,   1'b0, 1'b0, 16'sd0,      16'sd0);
		send_instr(KIND_STOP,   1'b0, 1'b0, 16'sd0,      16'sd0);
		send_instr(KIND_LABEL,  1'b1, 1'b0, 16'sd5,      16'sd0);
		send_instr(KIND_COPY,   1'b1, 1'b0, 16'sh8000,   16'sd0);
		send_instr(KIND_SLIDE,  1'b1, 1'b0, 16'sh7FFF,   16'sd0);
		send_instr(5'd24,       1'b0, 1'b0, 16'sd0,      16'sd0);
		send_instr(5'd31,       1'b1, 1'b1, 16'sh7FFF,   16'sh7FFF);

		// Random part: mostly sensible counts and labels, some out of range.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == HOLD_AT)
				hold_start = 1'b1;
			if (n == QUIET_FROM)
				idle_on = 1'b0;
			if ($urandom_range(0, 19) == 0)
				k = 5'($urandom_range(24, 31));
			else
				k = 5'($urandom_range(0, 23));
			p1 = $urandom_range(0, 1);
			p2 = $urandom_range(0, 1);
			v1 = rand_operand();
			v2 = rand_operand();
			repeat_form = ((k == KIND_DUP || k == KIND_DROP) && p1) ||
				(p2 && (k == KIND_PUTC || k == KIND_PUTN ||
				(k >= KIND_ADD && k <= KIND_MOD)));
			label_form = (k >= KIND_CALL && k <= KIND_BLTZ) || k == KIND_LABEL;
			if (repeat_form && $urandom_range(0, 9) < 8)
				v1 = 16'($urandom_range(0, MAX_REPEAT_DEF));
			if (label_form && $urandom_range(0, 9) < 8) begin
				p1 = 1'b1;
				v1 = v1 & 16'sh7FFF;
			end
			send_instr(k, p1, p2, v1, v2);
		end
		in_valid <= 1'b0;

		// Let the checker book the final beat, drain whatever is still owed, then settle.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d instructions giving %0d symbol beats,", item_count,
			symbol_count);
		$display("with %0d range errors and %0d divide-by-zero warnings.", error_count,
			warning_count);
		$display("Run included random stalls on both sides and one long consumer hold-off.");
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/sice_pkg.sv
hw/rtl/sice_decode.sv
hw/rtl/sice_ctrl.sv
hw/rtl/sice_dp.sv
hw/rtl/stack_instruction_char_encoder.sv
hw/rtl/sice_checker.sv
sim/symbol_stream_checker.sv
sim/stack_instruction_char_encoder_tb.sv
